// ===== sv/erf_pkg.sv =====
// Shared types and constants for the event record framer.
package erf_pkg;

	localparam int PENDING_DEPTH = 16;
	localparam int RECORD_BYTES  = 512;
	localparam int PEND_AW       = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int FILL_W        = $clog2(PENDING_DEPTH + 1);

	localparam logic [31:0] REC_MAGIC   = 32'h4c42_5245;
	localparam logic [31:0] REC_VERSION = 32'd1;
	localparam logic [31:0] REC_SIZE    = 32'(RECORD_BYTES);
	localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
	localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
	localparam int          CRC_SPAN    = 508;
	localparam int          BIDX_W      = 9;
	localparam int          DIV_STEPS   = 32;

	localparam logic [16:0] RING_COUNT_RST = 17'd64;

	localparam logic [1:0] CFG_BOOT_ID    = 2'd0;
	localparam logic [1:0] CFG_RING_START = 2'd1;
	localparam logic [1:0] CFG_RING_COUNT = 2'd2;

	localparam logic [2:0] ST_RECORD  = 3'd0;
	localparam logic [2:0] ST_QUEUED  = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_ZERO    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_ENABLE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] event_code;
		logic [31:0] arg_first;
		logic [31:0] arg_second;
		logic [31:0] arg_third;
		logic [31:0] arg_fourth;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] blk_addr;
		logic [31:0] sequence_number;
		logic [31:0] dropped_events;
		logic [31:0] out_event;
		logic [31:0] out_arg_first;
		logic [31:0] out_arg_second;
		logic [31:0] out_arg_third;
		logic [31:0] out_arg_fourth;
		logic [31:0] record_crc;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [31:0] code;
		logic [31:0] a0;
		logic [31:0] a1;
		logic [31:0] a2;
		logic [31:0] a3;
	} evt_t;

	localparam int EVT_W = $bits(evt_t);

endpackage

// ===== sv/event_record_framer_crc32_top.sv =====
// Event record framer: pending queue, ring addressing and record CRC sequencer.
// Non-record answers: result strobe registered at the accepting edge; busy stays low.
// Records: a flush of n queued events gives n results, each strobed once its
// byte-serial CRC and ring remainder are done.
// Reset clears configuration to defaults, counters, storage flag and queue fill; queued
// contents are not cleared. Results are strobed for one cycle; the receiver cannot stall.
module event_record_framer_crc32_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  erf_pkg::item_t   item,
	output logic             result_valid,
	output erf_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LATCH,
		S_RUN
	} state_t;

	state_t                      state_q;
	logic [31:0]                 boot_id_q;
	logic [31:0]                 ring_start_q;
	logic [16:0]                 ring_count_q;
	logic                        storage_on_q;
	logic [31:0]                 seq_q;
	logic [31:0]                 drop_q;
	logic [erf_pkg::FILL_W-1:0] fill_q;
	logic [erf_pkg::FILL_W-1:0] flush_idx_q;
	logic                        flushing_q;
	logic                        go_q;
	erf_pkg::evt_t               evt_q;
	erf_pkg::result_t            result_q;
	logic                        result_valid_q;

	logic                        accept;
	logic                        ram_we;
	erf_pkg::evt_t               in_evt;
	erf_pkg::evt_t               ram_rdata;
	logic [erf_pkg::BIDX_W-1:0] byte_idx;
	logic [7:0]                  crc_byte_in;
	logic [31:0]                 crc_val;
	logic                        crc_done;
	logic [16:0]                 rem_val;
	logic                        mod_done;
	logic [31:0]                 word_sel;
	logic                        last_flush;

	function automatic erf_pkg::result_t plain_result(input logic [2:0] st);
		erf_pkg::result_t r;
		r             = '0;
		r.status      = st;
		r.last_of_run = 1'b1;
		return r;
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign in_evt = '{code: item.event_code, a0: item.arg_first, a1: item.arg_second,
		a2: item.arg_third, a3: item.arg_fourth};

	assign ram_we = accept && (item.operation == erf_pkg::OP_APPEND)
		&& (item.event_code != 32'd0) && !storage_on_q
		&& (fill_q < erf_pkg::FILL_W'(erf_pkg::PENDING_DEPTH));

	erf_ram #(
		.WIDTH (erf_pkg::EVT_W),
		.DEPTH (erf_pkg::PENDING_DEPTH)
	) u_pend (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[erf_pkg::PEND_AW-1:0]),
		.wdata (in_evt),
		.raddr (flush_idx_q[erf_pkg::PEND_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		unique case (byte_idx[erf_pkg::BIDX_W-1:2])
			7'd0:    word_sel = erf_pkg::REC_MAGIC;
			7'd1:    word_sel = erf_pkg::REC_VERSION;
			7'd2:    word_sel = erf_pkg::REC_SIZE;
			7'd3:    word_sel = boot_id_q;
			7'd4:    word_sel = seq_q;
			7'd5:    word_sel = drop_q;
			7'd6:    word_sel = evt_q.code;
			7'd7:    word_sel = evt_q.a0;
			7'd8:    word_sel = evt_q.a1;
			7'd9:    word_sel = evt_q.a2;
			7'd10:   word_sel = evt_q.a3;
			default: word_sel = 32'd0;
		endcase
		crc_byte_in = word_sel[{byte_idx[1:0], 3'b000} +: 8];
	end

	erf_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_q),
		.data_byte (crc_byte_in),
		.byte_idx  (byte_idx),
		.crc       (crc_val),
		.done      (crc_done)
	);

	erf_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_q),
		.dividend  (seq_q),
		.divisor   (ring_count_q),
		.remainder (rem_val),
		.done      (mod_done)
	);

	assign last_flush = (flush_idx_q + erf_pkg::FILL_W'(1)) == fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			boot_id_q      <= '0;
			ring_start_q   <= '0;
			ring_count_q   <= erf_pkg::RING_COUNT_RST;
			storage_on_q   <= 1'b0;
			seq_q          <= '0;
			drop_q         <= '0;
			fill_q         <= '0;
			flush_idx_q    <= '0;
			flushing_q     <= 1'b0;
			go_q           <= 1'b0;
			evt_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			go_q           <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					erf_pkg::CFG_BOOT_ID:    boot_id_q    <= cfg_data;
					erf_pkg::CFG_RING_START: ring_start_q <= cfg_data;
					erf_pkg::CFG_RING_COUNT: ring_count_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (item.operation == erf_pkg::OP_ENABLE) begin
							storage_on_q <= 1'b1;
							if (fill_q == '0) begin
								result_q       <= plain_result(erf_pkg::ST_EMPTY);
								result_valid_q <= 1'b1;
							end else begin
								flush_idx_q <= '0;
								flushing_q  <= 1'b1;
								state_q     <= S_FETCH;
							end
						end else if (item.event_code == 32'd0) begin
							result_q       <= plain_result(erf_pkg::ST_ZERO);
							result_valid_q <= 1'b1;
						end else if (storage_on_q) begin
							evt_q      <= in_evt;
							flushing_q <= 1'b0;
							go_q       <= 1'b1;
							state_q    <= S_RUN;
						end else if (ram_we) begin
							fill_q         <= fill_q + 1'b1;
							result_q       <= plain_result(erf_pkg::ST_QUEUED);
							result_valid_q <= 1'b1;
						end else begin
							drop_q         <= drop_q + 1'b1;
							result_q       <= plain_result(erf_pkg::ST_DROPPED);
							result_valid_q <= 1'b1;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					evt_q   <= ram_rdata;
					go_q    <= 1'b1;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (!go_q && crc_done && mod_done) begin
						result_q.status          <= erf_pkg::ST_RECORD;
						result_q.blk_addr        <= ring_start_q + {15'd0, rem_val};
						result_q.sequence_number <= seq_q;
						result_q.dropped_events  <= drop_q;
						result_q.out_event       <= evt_q.code;
						result_q.out_arg_first   <= evt_q.a0;
						result_q.out_arg_second  <= evt_q.a1;
						result_q.out_arg_third   <= evt_q.a2;
						result_q.out_arg_fourth  <= evt_q.a3;
						result_q.record_crc      <= crc_val;
						result_q.last_of_run     <= !flushing_q || last_flush;
						result_valid_q           <= 1'b1;
						seq_q                    <= seq_q + 1'b1;
						if (flushing_q && !last_flush) begin
							flush_idx_q <= flush_idx_q + 1'b1;
							state_q     <= S_FETCH;
						end else begin
							if (flushing_q) begin
								fill_q <= '0;
							end
							flushing_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== sv/erf_ram.sv =====
// Generic single write port RAM with registered read.
module erf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/erf_crc.sv =====
// Byte-serial reflected CRC-32 engine over the record span.
module erf_crc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [7:0]                 data_byte,
	output logic [erf_pkg::BIDX_W-1:0] byte_idx,
	output logic [31:0]                crc,
	output logic                       done
);

	logic [31:0]                 crc_q;
	logic [erf_pkg::BIDX_W-1:0] idx_q;
	logic                        run_q;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? erf_pkg::CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			idx_q <= '0;
		end else if (run_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == erf_pkg::BIDX_W'(erf_pkg::CRC_SPAN - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= erf_pkg::CRC_INIT;
		end else if (run_q) begin
			crc_q <= crc_byte(crc_q, data_byte);
		end
	end

	assign byte_idx = idx_q;
	assign crc      = ~crc_q;
	assign done     = !run_q;

endmodule

// ===== sv/erf_mod.sv =====
// Bit-serial restoring remainder of the sequence number by the ring size.
module erf_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [16:0] divisor,
	output logic [16:0] remainder,
	output logic        done
);

	logic [31:0] dvd_q;
	logic [16:0] rem_q;
	logic [16:0] div_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [17:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'(erf_pkg::DIV_STEPS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == 17'd0) ? 17'd1 : divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[16:0];
			end else begin
				rem_q <= trial[16:0];
			end
		end
	end

	assign remainder = rem_q;
	assign done      = !run_q;

endmodule
